// File: rtl/kabf_pkg.sv
// ----------------------------------------------------------------------------
// kabf_pkg
// Shared widths, register indexes and limits of the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package kabf_pkg;

   // Q4.28 fraction bits and fixed field widths
   localparam int FRAC     = 28;
   localparam int Q_W      = 32;
   localparam int CFG_W    = 31;
   localparam int CSR_AW   = 2;
   // quotient bits left once the gain is known to stay below 2^31
   localparam int QUO_BITS = 31;

   typedef logic [CSR_AW-1:0] csr_addr_type;

   localparam csr_addr_type REG_STEP_TIME     = 2'd0;
   localparam csr_addr_type REG_ANGLE_NOISE   = 2'd1;
   localparam csr_addr_type REG_BIAS_NOISE    = 2'd2;
   localparam csr_addr_type REG_MEASURE_NOISE = 2'd3;

   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

endpackage

// File: rtl/kabf_mul.sv
// ----------------------------------------------------------------------------
// kabf_mul
// Shared Q4.28 multiplier: (a * b) >> 28, truncated toward zero. The 32-bit
// operand is consumed in two 16-bit halves, low half first.
// ----------------------------------------------------------------------------
module kabf_mul #(
   parameter int AW = 49
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [AW-1:0] op_a,
   input  logic signed [31:0]   op_b,
   output logic                 done,
   output logic signed [AW+4:0] result
);
   import kabf_pkg::*;

   typedef enum logic [1:0] {M_IDLE, M_LOW, M_HIGH, M_FIN} mstate_type;

   mstate_type            state_ff;
   logic [AW-1:0]         mag_a_ff;
   logic [31:0]           mag_b_ff;
   logic                  neg_ff;
   logic [AW+31:0]        acc_ff;
   logic                  done_ff;
   logic signed [AW+4:0]  result_ff;

   logic [AW-1:0]         mag_a_in;
   logic [31:0]           mag_b_in;
   logic [AW+15:0]        pp_lo;
   logic [AW+15:0]        pp_hi;
   logic [AW+4:0]         shifted;

   // operand magnitudes
   assign mag_a_in = op_a[AW-1] ? AW'(-op_a) : AW'(op_a);
   assign mag_b_in = op_b[31] ? 32'(-op_b) : 32'(op_b);

   // partial products of one 16-bit half
   assign pp_lo   = (AW+16)'(mag_a_ff) * (AW+16)'(mag_b_ff[15:0]);
   assign pp_hi   = (AW+16)'(mag_a_ff) * (AW+16)'(mag_b_ff[31:16]);
   assign shifted = {1'b0, acc_ff[AW+31:FRAC]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            M_IDLE: begin
               if (start) begin
                  mag_a_ff <= mag_a_in;
                  mag_b_ff <= mag_b_in;
                  neg_ff   <= op_a[AW-1] ^ op_b[31];
                  state_ff <= M_LOW;
               end
            end
            M_LOW: begin
               acc_ff   <= (AW+32)'(pp_lo);
               state_ff <= M_HIGH;
            end
            M_HIGH: begin
               acc_ff   <= acc_ff + ((AW+32)'(pp_hi) << 16);
               state_ff <= M_FIN;
            end
            M_FIN: begin
               // apply sign after truncation so rounding is toward zero
               result_ff <= neg_ff ? -$signed(shifted) : $signed(shifted);
               done_ff   <= 1'b1;
               state_ff  <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// File: rtl/kabf_div.sv
// ----------------------------------------------------------------------------
// kabf_div
// Gain divider: (p << 28) / s, truncated toward zero, saturated to Q4.28.
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kabf_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  num,
   input  logic [31:0]         den,
   output logic                done,
   output logic signed [31:0]  gain
);
   import kabf_pkg::*;

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_type;

   dstate_type             state_ff;
   logic                   neg_ff;
   logic                   sat_ff;
   logic [31:0]            den_ff;
   logic [31:0]            rem_ff;
   logic [QUO_BITS-1:0]    src_ff;
   logic [QUO_BITS-1:0]    quo_ff;
   logic [4:0]             cnt_ff;
   logic                   done_ff;
   logic signed [31:0]     gain_ff;

   logic [31:0]            mag_in;
   logic [32:0]            trial;
   logic                   fits;

   assign mag_in = num[31] ? 32'(-num) : 32'(num);
   assign trial  = {rem_ff, src_ff[QUO_BITS-1]};
   assign fits   = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  neg_ff <= num[31];
                  den_ff <= den;
                  quo_ff <= '0;
                  rem_ff <= {3'b000, mag_in[31:3]};
                  src_ff <= {mag_in[2:0], {FRAC{1'b0}}};
                  cnt_ff <= 5'(QUO_BITS);
                  // quotient of 2^31 or more saturates at once
                  if ({3'b000, mag_in} >= {den, 3'b000}) begin
                     sat_ff   <= 1'b1;
                     state_ff <= D_FIN;
                  end else begin
                     sat_ff   <= 1'b0;
                     state_ff <= D_RUN;
                  end
               end
            end
            D_RUN: begin
               rem_ff <= fits ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
               quo_ff <= {quo_ff[QUO_BITS-2:0], fits};
               src_ff <= src_ff << 1;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd1) begin
                  state_ff <= D_FIN;
               end
            end
            D_FIN: begin
               if (sat_ff) begin
                  gain_ff <= neg_ff ? Q_MIN : Q_MAX;
               end else begin
                  gain_ff <= neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
               end
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign gain = gain_ff;

endmodule

// File: rtl/kalman_angle_bias_filter.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// Two-state (angle, gyro bias) Kalman filter with one shared multiplier and
// one shared divider under a small sequencer.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Each beat runs predict, gain and correct through
// ten passes of the shared multiplier and two passes of the bit-serial gain
// divider, which skips its bit loop when the gain saturates. When P00 + R is
// not positive the divider is skipped and both gains are zero. The input side
// is not ready while a beat is in work; a finished result waits in the output
// register and the next beat may be taken meanwhile, but a beat that finishes
// while the previous result still waits holds until that result is taken.
// Registers are to be written through the csr port only while the block is
// idle; the block itself does not enforce this.
module kalman_angle_bias_filter #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  kabf_pkg::csr_addr_type        csr_addr,
   input  logic [kabf_pkg::CFG_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [31:0]            req_measured_angle,
   input  logic signed [31:0]            req_measured_rate,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_filtered_angle,
   output logic signed [31:0]            rsp_corrected_rate,
   output logic signed [31:0]            rsp_bias_estimate
);
   import kabf_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int RW = ((DW > Q_W) ? DW : Q_W) + 1;
   localparam int AW = (RW > 38) ? RW : 38;
   localparam int MW = AW + 5;
   localparam int SW = MW + 1;

   localparam logic signed [SW-1:0] DW_MAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [SW-1:0] DW_MIN = ~DW_MAX;
   localparam logic signed [SW-1:0] W32_MAX = {{(SW-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
   localparam logic signed [SW-1:0] W32_MIN = ~W32_MAX;

   typedef enum logic [3:0] {
      S_IDLE, S_RATE, S_TBB, S_INNER, S_P11, S_K0, S_K1,
      S_BIAS, S_ANG, S_AA, S_AB, S_BA, S_BB, S_OUT
   } state_type;

   function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
      if (v > DW_MAX) return DW_MAX[DW-1:0];
      if (v < DW_MIN) return DW_MIN[DW-1:0];
      return v[DW-1:0];
   endfunction

   function automatic logic signed [31:0] sat_32(input logic signed [SW-1:0] v);
      if (v > W32_MAX) return Q_MAX;
      if (v < W32_MIN) return Q_MIN;
      return v[31:0];
   endfunction

   // configuration
   logic [CFG_W-1:0]        step_time_ff, angle_noise_ff, bias_noise_ff, measure_noise_ff;

   // filter state and per-beat temporaries
   state_type               state_ff;
   logic                    issued_ff;
   logic signed [DW-1:0]    angle_ff, bias_ff;
   logic signed [31:0]      cov_aa_ff, cov_ab_ff, cov_ba_ff, cov_bb_ff;
   logic signed [31:0]      p00_ff, p01_ff, p10_ff, p11_ff, k0_ff, k1_ff;
   logic signed [SW-1:0]    rate_ff, tbb_ff;
   logic signed [31:0]      z_ff;
   logic                    rsp_valid_ff;
   logic signed [31:0]      out_angle_ff, out_rate_ff, out_bias_ff;

   // shared unit ports
   logic                    mul_start, mul_done, div_start, div_done;
   logic signed [AW-1:0]    mul_a;
   logic signed [31:0]      mul_b, div_num, div_gain;
   logic signed [MW-1:0]    mul_res;
   logic signed [SW-1:0]    m;
   logic signed [SW-1:0]    rate_in, inner, y;
   logic signed [32:0]      s_in;
   logic                    is_mul;

   assign m       = SW'(mul_res);
   assign rate_in = SW'(req_measured_rate) - SW'(bias_ff);
   assign inner   = tbb_ff - SW'(cov_ab_ff) - SW'(cov_ba_ff)
                    + SW'({1'b0, angle_noise_ff});
   assign y       = SW'(z_ff) - SW'(angle_ff);
   assign s_in    = 33'(p00_ff) + $signed({2'b00, measure_noise_ff});

   // route operands to the multiplier
   always_comb begin
      is_mul = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_RATE:  begin mul_a = AW'(rate_ff);  mul_b = {1'b0, step_time_ff}; end
         S_TBB:   begin mul_a = AW'(cov_bb_ff); mul_b = {1'b0, step_time_ff}; end
         S_INNER: begin mul_a = AW'(inner);    mul_b = {1'b0, step_time_ff}; end
         S_P11: begin
            mul_a = AW'($signed({1'b0, bias_noise_ff}));
            mul_b = {1'b0, step_time_ff};
         end
         S_BIAS:  begin mul_a = AW'(y);      mul_b = k1_ff; end
         S_ANG:   begin mul_a = AW'(y);      mul_b = k0_ff; end
         S_AA:    begin mul_a = AW'(p00_ff); mul_b = k0_ff; end
         S_AB:    begin mul_a = AW'(p01_ff); mul_b = k0_ff; end
         S_BA:    begin mul_a = AW'(p00_ff); mul_b = k1_ff; end
         S_BB:    begin mul_a = AW'(p01_ff); mul_b = k1_ff; end
         default: is_mul = 1'b0;
      endcase
   end

   assign mul_start = is_mul && !issued_ff;
   assign div_start = (state_ff == S_K0 || state_ff == S_K1) && !issued_ff;
   assign div_num   = (state_ff == S_K0) ? p00_ff : p10_ff;

   kabf_mul #(.AW(AW)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   kabf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (s_in[31:0]),
      .done  (div_done),
      .gain  (div_gain)
   );

   // sequencer, state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         issued_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         step_time_ff     <= CFG_W'(2684355);
         angle_noise_ff   <= CFG_W'(268435);
         bias_noise_ff    <= CFG_W'(805306);
         measure_noise_ff <= CFG_W'(161061274);
         angle_ff         <= '0;
         bias_ff          <= '0;
         cov_aa_ff        <= '0;
         cov_ab_ff        <= '0;
         cov_ba_ff        <= '0;
         cov_bb_ff        <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_STEP_TIME:     step_time_ff     <= csr_wdata;
               REG_ANGLE_NOISE:   angle_noise_ff   <= csr_wdata;
               REG_BIAS_NOISE:    bias_noise_ff    <= csr_wdata;
               REG_MEASURE_NOISE: measure_noise_ff <= csr_wdata;
               default: ;
            endcase
         end

         // drop the result once taken
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (mul_start || div_start) begin
            issued_ff <= 1'b1;
         end

         if (mul_done) begin
            issued_ff <= 1'b0;
         end
         if (div_done) begin
            issued_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  z_ff     <= req_measured_angle;
                  rate_ff  <= rate_in;
                  state_ff <= S_RATE;
               end
            end
            S_RATE: if (mul_done) begin
               angle_ff <= sat_dw(SW'(angle_ff) + m);
               state_ff <= S_TBB;
            end
            S_TBB: if (mul_done) begin
               tbb_ff   <= m;
               state_ff <= S_INNER;
            end
            S_INNER: if (mul_done) begin
               p00_ff   <= sat_32(SW'(cov_aa_ff) + m);
               p01_ff   <= sat_32(SW'(cov_ab_ff) - tbb_ff);
               p10_ff   <= sat_32(SW'(cov_ba_ff) - tbb_ff);
               state_ff <= S_P11;
            end
            S_P11: if (mul_done) begin
               p11_ff <= sat_32(SW'(cov_bb_ff) + m);
               // non-positive innovation variance: zero gains, skip divider
               if (s_in > 33'sd0) begin
                  state_ff <= S_K0;
               end else begin
                  k0_ff    <= '0;
                  k1_ff    <= '0;
                  state_ff <= S_BIAS;
               end
            end
            S_K0: if (div_done) begin
               k0_ff    <= div_gain;
               state_ff <= S_K1;
            end
            S_K1: if (div_done) begin
               k1_ff    <= div_gain;
               state_ff <= S_BIAS;
            end
            S_BIAS: if (mul_done) begin
               bias_ff  <= sat_dw(SW'(bias_ff) + m);
               state_ff <= S_ANG;
            end
            S_ANG: if (mul_done) begin
               angle_ff <= sat_dw(SW'(angle_ff) + m);
               state_ff <= S_AA;
            end
            S_AA: if (mul_done) begin
               cov_aa_ff <= sat_32(SW'(p00_ff) - m);
               state_ff  <= S_AB;
            end
            S_AB: if (mul_done) begin
               cov_ab_ff <= sat_32(SW'(p01_ff) - m);
               state_ff  <= S_BA;
            end
            S_BA: if (mul_done) begin
               cov_ba_ff <= sat_32(SW'(p10_ff) - m);
               state_ff  <= S_BB;
            end
            S_BB: if (mul_done) begin
               cov_bb_ff <= sat_32(SW'(p11_ff) - m);
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  out_angle_ff <= sat_32(SW'(angle_ff));
                  out_rate_ff  <= sat_32(rate_ff);
                  out_bias_ff  <= sat_32(SW'(bias_ff));
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_angle = out_angle_ff;
   assign rsp_corrected_rate = out_rate_ff;
   assign rsp_bias_estimate  = out_bias_ff;

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the angle/bias Kalman filter. A directed table and a
// long random run are driven through the request channel under several
// register settings. Each accepted beat is run through a local fixed-point
// copy of the filter, and every response beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import kabf_pkg::*;

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] rate;
      logic signed [31:0] bias;
   } reading_type;

   typedef struct {
      logic signed [31:0] angle_in;
      logic signed [31:0] rate_in;
      bit                 typed;
      reading_type        want;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   csr_addr_type           csr_addr;
   logic [CFG_W-1:0]       csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   logic signed [31:0]     req_measured_angle;
   logic signed [31:0]     req_measured_rate;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic signed [31:0]     rsp_filtered_angle;
   logic signed [31:0]     rsp_corrected_rate;
   logic signed [31:0]     rsp_bias_estimate;

   kalman_angle_bias_filter uut (.*);

   // filter model state and register copies
   longint step_dt, q_angle, q_bias, r_meas;
   longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

   reading_type pending_readings[$];
   int          mismatches;
   int          burst_left;

   initial begin
      clock = 1'b0;
   end
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic longint sat_to(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // exact product shifted down by the Q4.28 fraction, toward zero, int64-saturated
   function automatic longint q28_mul(longint a, longint b);
      logic signed [127:0] sa;
      logic signed [127:0] sb;
      logic [127:0]        prod;
      logic [127:0]        lim;
      bit                  neg;
      sa = a;
      sb = b;
      neg = (a < 0) != (b < 0);
      if (sa < 0) sa = -sa;
      if (sb < 0) sb = -sb;
      prod = (128'(sa) * 128'(sb)) >> FRAC;
      lim = neg ? (128'(1) << 63) : ((128'(1) << 63) - 1);
      if (prod > lim) prod = lim;
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
   endfunction

   function automatic longint kalman_gain(longint p, longint s);
      longint mag;
      longint q;
      mag = (p < 0) ? -p : p;
      q = (mag <<< FRAC) / s;
      return sat_to((p < 0) ? -q : q, 32);
   endfunction

   function automatic void filter_reset();
      step_dt = 2684355;
      q_angle = 268435;
      q_bias = 805306;
      r_meas = 161061274;
      est_angle = 0;
      est_bias = 0;
      p_aa = 0;
      p_ab = 0;
      p_ba = 0;
      p_bb = 0;
   endfunction

   // one predict/gain/correct pass of the filter
   function automatic reading_type filter_update(logic signed [31:0] z_in,
                                                 logic signed [31:0] w_in);
      longint      z, w, rate, inner, s, k0, k1, y;
      longint      p00, p01, p10, p11;
      reading_type res;
      z = z_in;
      w = w_in;
      rate = w - est_bias;
      est_angle = sat_to(est_angle + q28_mul(step_dt, rate), 32);
      inner = q28_mul(step_dt, p_bb) - p_ab - p_ba + q_angle;
      p00 = sat_to(p_aa + q28_mul(step_dt, inner), 32);
      p01 = sat_to(p_ab - q28_mul(step_dt, p_bb), 32);
      p10 = sat_to(p_ba - q28_mul(step_dt, p_bb), 32);
      p11 = sat_to(p_bb + q28_mul(q_bias, step_dt), 32);
      s = p00 + r_meas;
      if (s > 0) begin
         k0 = kalman_gain(p00, s);
         k1 = kalman_gain(p10, s);
      end else begin
         k0 = 0;
         k1 = 0;
      end
      y = z - est_angle;
      est_angle = sat_to(est_angle + q28_mul(k0, y), 32);
      est_bias = sat_to(est_bias + q28_mul(k1, y), 32);
      p_aa = sat_to(p00 - q28_mul(k0, p00), 32);
      p_ab = sat_to(p01 - q28_mul(k0, p01), 32);
      p_ba = sat_to(p10 - q28_mul(k1, p00), 32);
      p_bb = sat_to(p11 - q28_mul(k1, p01), 32);
      res.angle = 32'(sat_to(est_angle, 32));
      res.rate = 32'(sat_to(rate, 32));
      res.bias = 32'(sat_to(est_bias, 32));
      return res;
   endfunction

   // write all four registers on back-to-back cycles, then drop the enable
   task automatic program_filter(longint dt, longint qa, longint qb, longint rn);
      longint vals[4];
      vals = '{dt, qa, qb, rn};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_addr <= csr_addr_type'(i);
         csr_wdata <= CFG_W'(vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      step_dt = vals[REG_STEP_TIME] & 64'h7FFF_FFFF;
      q_angle = vals[REG_ANGLE_NOISE] & 64'h7FFF_FFFF;
      q_bias = vals[REG_BIAS_NOISE] & 64'h7FFF_FFFF;
      r_meas = vals[REG_MEASURE_NOISE] & 64'h7FFF_FFFF;
   endtask

   // hold the beat until accepted, then queue its expected reading
   task automatic send_beat(logic signed [31:0] angle_in, logic signed [31:0] rate_in,
                            bit typed, reading_type want);
      reading_type pred;
      int          gap;
      req_valid <= 1'b1;
      req_measured_angle <= angle_in;
      req_measured_rate <= rate_in;
      do @(posedge clock); while (!req_ready);
      pred = filter_update(angle_in, rate_in);
      pending_readings.push_back(typed ? want : pred);
      // bursts of back-to-back beats, random gaps between them
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // drop valid so the last beat is not taken twice, then wait for all responses
   task automatic drain_readings();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 11796480)) - 32'sd5898240;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
      endcase
   endfunction

   // random beats: mostly smooth tracks of a moving angle, some noise and jumps
   task automatic random_phase(int count);
      longint      track_angle, track_rate;
      reading_type none;
      int          mode;
      none = '0;
      track_angle = $signed($urandom_range(0, 11796480)) - 5898240;
      track_rate = $signed($urandom_range(0, 655360)) - 327680;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 9);
         if (mode < 7) begin
            if ($urandom_range(0, 40) == 0)
               track_rate = $signed($urandom_range(0, 655360)) - 327680;
            track_angle = sat_to(track_angle + track_rate / 100, 32);
            send_beat(32'(track_angle + $signed($urandom_range(0, 131072)) - 65536),
                      32'(track_rate + $signed($urandom_range(0, 32768)) - 16384),
                      1'b0, none);
         end else if (mode < 9) begin
            send_beat(pick_value(0), pick_value($urandom_range(0, 1)), 1'b0, none);
         end else begin
            send_beat(pick_value(2), pick_value(2), 1'b0, none);
         end
      end
      drain_readings();
   endtask

   // receiver stall pattern; the style is re-drawn at random whenever the low six bits of the tick are all ones
   int stall_mode;
   int stall_tick;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_tick <= 0;
         stall_mode <= 0;
      end else begin
         stall_tick <= stall_tick + 1;
         if (stall_tick[5:0] == 6'd63) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= (stall_tick[1:0] != 2'd0);
            2: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= (stall_tick[3:0] == 4'd0);
         endcase
      end
   end

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat at %0t", $realtime);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_filtered_angle !== want.angle || rsp_corrected_rate !== want.rate ||
                rsp_bias_estimate !== want.bias) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: angle %h/%h rate %h/%h bias %h/%h (exp/got)",
                           $realtime, want.angle, rsp_filtered_angle, want.rate,
                           rsp_corrected_rate, want.bias, rsp_bias_estimate);
            end
         end
      end
   end

   stim_row_type rows[$];

   initial begin
      mismatches = 0;
      burst_left = 0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_addr <= REG_STEP_TIME;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_measured_angle <= '0;
      req_measured_rate <= '0;
      filter_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; the first row out of reset is all zeros
      rows.push_back('{32'sd0, 32'sd0, 1'b1, '0});
      rows.push_back('{32'sh7FFF_FFFF, 32'sd0, 1'b0, '0});
      rows.push_back('{32'sh8000_0000, 32'sd0, 1'b0, '0});
      rows.push_back('{32'sd0, 32'sh7FFF_FFFF, 1'b0, '0});
      rows.push_back('{32'sd0, 32'sh8000_0000, 1'b0, '0});
      rows.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, '0});
      rows.push_back('{32'sh8000_0000, 32'sh8000_0000, 1'b0, '0});
      rows.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, '0});
      rows.push_back('{-32'sd1, 32'sd1, 1'b0, '0});
      rows.push_back('{32'sd1, -32'sd1, 1'b0, '0});
      rows.push_back('{32'sh0005_A000, 32'sh0000_8000, 1'b0, '0});
      rows.push_back('{-32'sh0005_A000, -32'sh0000_8000, 1'b0, '0});
      foreach (rows[i]) send_beat(rows[i].angle_in, rows[i].rate_in, rows[i].typed,
                                  rows[i].want);
      drain_readings();

      // zero step time leaves angle and covariance unchanged through the predict step
      program_filter(0, 268435, 805306, 161061274);
      foreach (rows[i]) send_beat(rows[i].angle_in, rows[i].rate_in, 1'b0, '0);
      drain_readings();

      // extreme settings drive covariance and gain saturation
      program_filter(64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 1);
      random_phase(150);
      program_filter(1, 0, 0, 64'h7FFF_FFFF);
      random_phase(150);
      program_filter(64'h7FFF_FFFF, 0, 64'h7FFF_FFFF, 64'h7FFF_FFFF);
      random_phase(150);
      program_filter(2684355, 268435, 805306, 161061274);
      random_phase(400);
      for (int ph = 0; ph < 5; ph++) begin
         program_filter($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 24),
                        $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 24),
                        $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 24),
                        $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 24) | 1);
         random_phase(200);
      end

      if (mismatches == 0 && pending_readings.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
